### rtl/core/chkv_pkg.sv
// ----------------------------------------------------------------------------
// chkv_pkg
// Shared types and constants for the chained hash key-value store.
// ----------------------------------------------------------------------------
`default_nettype none

package chkv_pkg;

    localparam int unsigned LOG2_MAX_SIZE_DEF = 12;
    localparam int unsigned KEY_W             = 64;
    localparam int unsigned VAL_W             = 8;
    localparam int unsigned CFG_W             = 4;
    localparam logic [CFG_W-1:0] LOG2_RESET   = 4'd12;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_INSERT,
        S_ENTRY_RD,
        S_ENTRY_WAIT,
        S_CHECK,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input beat
        logic hash_step;  // advance hash pipeline one step
        logic clr_wr;     // write empty marker at clear address
        logic ins_wr;     // write entry and new head
        logic ent_rd;     // read entry at walk pointer
        logic take_link;  // walk pointer from link
        logic take_head;  // walk pointer from head
        logic set_hit;    // record match
        logic set_full;   // record dropped insert
        logic out_load;   // present result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic hash_done;
        logic is_lookup;
        logic full;
        logic ptr_empty;
        logic key_match;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

### rtl/core/chkv_if.sv
// ----------------------------------------------------------------------------
// chkv_req_if / chkv_rsp_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface chkv_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [63:0] key;
    logic [7:0]  value;
    modport source (output valid, output operation, output key, output value, input ready);
    modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

interface chkv_rsp_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [7:0] found_value;
    logic       status;
    modport source (output valid, output found, output found_value, output status, input ready);
    modport sink   (input valid, input found, input found_value, input status, output ready);
endinterface

`default_nettype wire

### rtl/core/chkv_ram.sv
// ----------------------------------------------------------------------------
// chkv_ram
// Single-port-write, one-read generic RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chkv_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

### rtl/core/chkv_datapath.sv
// ----------------------------------------------------------------------------
// chkv_datapath
// Hash pipeline, bucket and entry memories, walk pointer, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module chkv_datapath #(
    parameter int unsigned LOG2_MAX_SIZE = chkv_pkg::LOG2_MAX_SIZE_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_we,
    input  wire logic [chkv_pkg::CFG_W-1:0] i_cfg_data,
    input  wire chkv_pkg::t_cmd           i_cmd,
    output chkv_pkg::t_status             o_sts,
    chkv_req_if.sink                      req,
    chkv_rsp_if.source                    rsp
);
    import chkv_pkg::*;

    localparam int unsigned IW = LOG2_MAX_SIZE;
    localparam int unsigned PW = LOG2_MAX_SIZE + 1;
    localparam int unsigned SIZE = 1 << LOG2_MAX_SIZE;

    logic [CFG_W-1:0] r_log2;
    logic             r_op;
    logic [KEY_W-1:0] r_key, r_hash;
    logic [VAL_W-1:0] r_val;
    logic [2:0]       r_hstep;
    logic [IW-1:0]    r_clr_addr;
    logic             r_clr_done;
    logic [PW-1:0]    r_count;
    logic [PW-1:0]    r_ptr;
    logic             r_hit, r_full;
    logic [VAL_W-1:0] r_hit_val;
    logic             r_ovalid, r_ofound, r_ostatus;
    logic [VAL_W-1:0] r_ovalue;

    logic [CFG_W-1:0] n_log2;
    logic [KEY_W-1:0] n_hash;
    logic [IW-1:0]    bucket, mask;
    logic [PW-1:0]    size;
    logic [PW-1:0]    head_rdata, link_rdata;
    logic [KEY_W-1:0] key_rdata;
    logic [VAL_W-1:0] val_rdata;
    logic             head_we;
    logic [IW-1:0]    head_waddr;
    logic [PW-1:0]    head_wdata;

    always_comb begin
        if (i_cfg_data == '0) n_log2 = CFG_W'(1);
        else if (32'(i_cfg_data) > LOG2_MAX_SIZE) n_log2 = CFG_W'(LOG2_MAX_SIZE);
        else n_log2 = i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= (32'(LOG2_RESET) > LOG2_MAX_SIZE) ? CFG_W'(LOG2_MAX_SIZE) : LOG2_RESET;
        end else if (i_cfg_we) begin
            r_log2 <= n_log2;
        end
    end

    // one mixing stage per step
    always_comb begin
        unique case (r_hstep)
            3'd0:    n_hash = ~r_hash + (r_hash << 21);
            3'd1:    n_hash = r_hash ^ (r_hash >> 24);
            3'd2:    n_hash = r_hash + (r_hash << 3) + (r_hash << 8);
            3'd3:    n_hash = r_hash ^ (r_hash >> 14);
            3'd4:    n_hash = r_hash + (r_hash << 2) + (r_hash << 4);
            3'd5:    n_hash = r_hash ^ (r_hash >> 28);
            3'd6:    n_hash = r_hash + (r_hash << 31);
            default: n_hash = r_hash;
        endcase
    end

    assign size   = PW'(1) << r_log2;
    assign mask   = IW'(size - PW'(1));
    assign bucket = r_hash[IW-1:0] & mask;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= req.operation;
            r_key   <= req.key;
            r_val   <= req.value;
            r_hash  <= req.key;
        end else if (i_cmd.hash_step) begin
            r_hash <= n_hash;
        end
        if (i_cmd.take_head) r_ptr <= head_rdata;
        else if (i_cmd.take_link) r_ptr <= link_rdata;
        if (i_cmd.set_hit) r_hit_val <= val_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hstep    <= '0;
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
            r_count    <= '0;
            r_hit      <= 1'b0;
            r_full     <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_hstep <= '0;
                r_hit   <= 1'b0;
                r_full  <= 1'b0;
            end else if (i_cmd.hash_step) begin
                r_hstep <= r_hstep + 3'd1;
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + IW'(1);
                if (r_clr_addr == IW'(SIZE - 1)) r_clr_done <= 1'b1;
            end
            if (i_cmd.ins_wr) r_count <= r_count + PW'(1);
            if (i_cmd.set_hit) r_hit <= 1'b1;
            if (i_cmd.set_full) r_full <= 1'b1;
            if (i_cmd.out_load) r_ovalid <= 1'b1;
            else if (rsp.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ofound  <= r_hit;
            r_ovalue  <= r_hit ? r_hit_val : '0;
            r_ostatus <= r_full;
        end
    end

    assign head_we    = i_cmd.clr_wr | i_cmd.ins_wr;
    assign head_waddr = i_cmd.clr_wr ? r_clr_addr : bucket;
    assign head_wdata = i_cmd.clr_wr ? {1'b1, {IW{1'b0}}} : r_count;

    chkv_ram #(.WIDTH(PW), .DEPTH(SIZE)) u_heads (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(bucket), .o_rdata(head_rdata)
    );
    chkv_ram #(.WIDTH(KEY_W), .DEPTH(SIZE)) u_keys (
        .i_clk(i_clk), .i_we(i_cmd.ins_wr), .i_waddr(r_count[IW-1:0]), .i_wdata(r_key),
        .i_raddr(r_ptr[IW-1:0]), .o_rdata(key_rdata)
    );
    chkv_ram #(.WIDTH(VAL_W), .DEPTH(SIZE)) u_vals (
        .i_clk(i_clk), .i_we(i_cmd.ins_wr), .i_waddr(r_count[IW-1:0]), .i_wdata(r_val),
        .i_raddr(r_ptr[IW-1:0]), .o_rdata(val_rdata)
    );
    chkv_ram #(.WIDTH(PW), .DEPTH(SIZE)) u_links (
        .i_clk(i_clk), .i_we(i_cmd.ins_wr), .i_waddr(r_count[IW-1:0]), .i_wdata(head_rdata),
        .i_raddr(r_ptr[IW-1:0]), .o_rdata(link_rdata)
    );

    assign o_sts.clr_done  = r_clr_done;
    assign o_sts.hash_done = (r_hstep == 3'd7);
    assign o_sts.is_lookup = (r_op == OP_LOOKUP);
    assign o_sts.full      = (r_count + PW'(1)) >= size;
    assign o_sts.ptr_empty = r_ptr[PW-1];
    assign o_sts.key_match = (key_rdata == r_key);
    assign o_sts.out_busy  = r_ovalid & ~rsp.ready;

    assign req.ready       = 1'b0 | i_cmd.load;
    assign rsp.valid       = r_ovalid;
    assign rsp.found       = r_ofound;
    assign rsp.found_value = r_ovalue;
    assign rsp.status      = r_ostatus;
endmodule

`default_nettype wire

### rtl/core/chkv_ctrl.sv
// ----------------------------------------------------------------------------
// chkv_ctrl
// Sequencer: clear sweep, hashing, insert, chain walk, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module chkv_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire chkv_pkg::t_status i_sts,
    output chkv_pkg::t_cmd         o_cmd,
    output chkv_pkg::t_state       o_state
);
    import chkv_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_done) begin
                    o_cmd.clr_wr = 1'b0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (i_sts.hash_done) n_state = S_HEAD_RD;
                else o_cmd.hash_step = 1'b1;
            end
            S_HEAD_RD: n_state = S_HEAD_WAIT;
            S_HEAD_WAIT: begin
                if (i_sts.is_lookup) begin
                    o_cmd.take_head = 1'b1;
                    n_state = S_ENTRY_RD;
                end else if (i_sts.full) begin
                    o_cmd.set_full = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_INSERT: begin
                o_cmd.ins_wr = 1'b1;
                n_state = S_OUT;
            end
            S_ENTRY_RD: begin
                if (i_sts.ptr_empty) n_state = S_OUT;
                else n_state = S_ENTRY_WAIT;
            end
            S_ENTRY_WAIT: n_state = S_CHECK;
            S_CHECK: begin
                if (i_sts.key_match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.take_link = 1'b1;
                    n_state = S_ENTRY_RD;
                end
            end
            S_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_state = r_state;
endmodule

`default_nettype wire

### rtl/core/chained_hash_key_value_store.sv
// ----------------------------------------------------------------------------
// chained_hash_key_value_store
// Hash table with separate chaining: insert or look up 64-bit keys.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one beat per item (operation, key, value). ready is high
//    for one cycle in idle when valid is seen; the beat is taken there.
//  - rsp channel: one beat per item (found, found_value, status), held in an
//    output register until the sink takes it.
//  - cfg: i_cfg_we/i_cfg_data write table_log2_size (0 reads as 1, values
//    above LOG2_MAX_SIZE are clamped). Write only while idle.
//  - Processing after the accepting edge: the hash steps run, then the
//    bucket head is read; an insert then writes the entry and new head
//    and loads the output, or is dropped as full. A lookup reads and
//    checks one chain entry after another until a hit or the chain's end.
//  - One item at a time; the next beat can be taken in the cycle after the
//    result is loaded into the output register.
//  - Reset: a clear sweep writes the empty marker into all 2^LOG2_MAX_SIZE
//    bucket heads, during which no beat is accepted.
//  - A stalled sink holds the result; the sequencer waits in its output
//    state until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_key_value_store #(
    parameter int unsigned LOG2_MAX_SIZE = chkv_pkg::LOG2_MAX_SIZE_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [chkv_pkg::CFG_W-1:0] i_cfg_data,
    chkv_req_if.sink                        req,
    chkv_rsp_if.source                      rsp
);
    import chkv_pkg::*;

    t_cmd    cmd;
    t_status sts;
    t_state  state;

    chkv_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req_valid(req.valid),
        .i_sts(sts), .o_cmd(cmd), .o_state(state)
    );

    chkv_datapath #(.LOG2_MAX_SIZE(LOG2_MAX_SIZE)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_cmd(cmd), .o_sts(sts), .req(req), .rsp(rsp)
    );

`ifndef SYNTHESIS
    // no beat taken during the clear sweep
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (state == S_CLEAR) |-> !req.ready)
        else $error("beat accepted during clear");
    // result register never overwritten while still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.valid && !rsp.ready) |-> !cmd.out_load)
        else $error("result overwritten");
    // insert never writes when full
    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.ins_wr |-> !sts.full)
        else $error("insert into full table");
`endif
endmodule

`default_nettype wire
